// ===== rtl/ptd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task dispatcher package
// Shared widths, operation codes, slot table entry and divider interface types.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int TASK_SLOTS_DEF = 8;
	localparam int TICK_W         = 16;
	localparam int PERIOD_W       = 16;
	localparam int OP_W           = 3;
	localparam int SLOT_W         = 3;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
	localparam logic [OP_W-1:0] OP_SUSPEND = 3'd2;
	localparam logic [OP_W-1:0] OP_RESUME  = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;

	// one slot table entry
	typedef struct packed {
		logic                occupied;
		logic                resumed;
		logic [PERIOD_W-1:0] period;
	} slot_entry_t;

	// remainder unit request and response
	typedef struct packed {
		logic                start;
		logic [TICK_W-1:0]   dividend;
		logic [PERIOD_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_rsp_t;

endpackage

// ===== rtl/ptd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ptd_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ptd_rem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division, one quotient bit per cycle; flags a zero remainder.
// ----------------------------------------------------------------------------
module ptd_rem
	import ptd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rem_req_t req,
	output rem_rsp_t rsp
);

	localparam int CW = $clog2(TICK_W);

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [TICK_W-1:0]   dvd_q;
	logic [PERIOD_W-1:0] dsr_q;
	logic [PERIOD_W:0]   trial;

	assign trial = {rem_q, dvd_q[TICK_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dvd_q  <= req.dividend;
				dsr_q  <= req.divisor;
			end else if (busy_q) begin
				if (trial >= {1'b0, dsr_q}) begin
					rem_q <= PERIOD_W'(trial - {1'b0, dsr_q});
				end else begin
					rem_q <= PERIOD_W'(trial);
				end
				dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(TICK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.zero = (rem_q == '0);

endmodule

// ===== rtl/periodic_task_dispatcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task dispatcher
// Slot table in a RAM, tick counter and a sequencer that walks the slots.
// ----------------------------------------------------------------------------
// Edits pass S_OP_WAIT (table write back), then S_ACK registers the acknowledge;
// other operations go straight to S_ACK. Tick: each slot is read (S_TK_RD,
// S_TK_WAIT), an eligible one is checked in S_TK_DIV, a due one is emitted in
// S_TK_EMIT, S_TK_DONE closes; stalls hold the emitting states. One transaction
// at a time; the next is taken once the last result is registered.
// Reset: control cleared at once; per-slot valid flags make the table read empty.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher
	import ptd_pkg::*;
#(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [SLOT_W-1:0]   slot,
	input  logic                has_function,
	input  logic [PERIOD_W-1:0] period,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic                status,
	output logic [SLOT_W-1:0]   due_slot,
	output logic                last
);

	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int EW = $bits(slot_entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_OP_WAIT,   // table entry arrives, write back
		S_ACK,
		S_TK_RD,     // read slot idx
		S_TK_WAIT,   // entry arrives, start period check if eligible
		S_TK_DIV,
		S_TK_EMIT,
		S_TK_DONE
	} state_t;

	state_t              state_q;
	logic [TICK_W-1:0]   tick_q;
	logic [SW-1:0]       idx_q;
	logic [OP_W-1:0]     op_q;
	logic [SW-1:0]       slot_q;
	logic [PERIOD_W-1:0] period_q;
	logic                ack_err_q;

	// result register
	logic                out_valid_q;
	logic                kind_q;
	logic                status_q;
	logic [SLOT_W-1:0]   due_slot_q;
	logic                last_q;

	// table valid flags
	logic [TASK_SLOTS-1:0] vld_q;
	logic                  rvld_s1;

	logic          ram_we;
	logic          ram_re;
	logic [SW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	slot_entry_t   cur_entry;
	slot_entry_t   nxt_entry;

	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	logic accept;
	logic out_free;
	logic emit;
	logic last_slot;
	logic in_range;
	logic edits;
	logic eligible;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign last_slot = (idx_q == SW'(TASK_SLOTS - 1));
	assign in_range  = (32'(slot) < TASK_SLOTS);

	// result register loads in this cycle
	assign emit = out_free && (state_q inside {S_ACK, S_TK_EMIT, S_TK_DONE});

	// operations that touch the table
	assign edits = in_range && ((operation == OP_CREATE && has_function)
		|| operation == OP_SUSPEND || operation == OP_RESUME
		|| operation == OP_DELETE);

	// read is issued straight at acceptance for edits; for a tick it is harmless
	assign ram_re    = accept || (state_q == S_TK_RD);
	assign ram_raddr = (state_q == S_IDLE) ? SW'(slot) : idx_q;
	assign ram_we    = (state_q == S_OP_WAIT);

	// a slot never written reads as empty
	assign cur_entry = rvld_s1 ? slot_entry_t'(ram_rdata) : '0;

	always_comb begin
		nxt_entry = cur_entry;
		case (op_q)
			OP_CREATE: begin
				if (!cur_entry.occupied) begin
					nxt_entry.occupied = 1'b1;
					nxt_entry.resumed  = 1'b1;
					nxt_entry.period   = period_q;
				end
			end
			OP_SUSPEND: nxt_entry.resumed  = 1'b0;
			OP_RESUME:  nxt_entry.resumed  = 1'b1;
			OP_DELETE:  nxt_entry.occupied = 1'b0;
			default:    nxt_entry = cur_entry;
		endcase
	end

	// zero period is never due
	assign eligible = cur_entry.occupied && cur_entry.resumed && (cur_entry.period != '0);

	assign rem_req.start    = (state_q == S_TK_WAIT) && eligible;
	assign rem_req.dividend = tick_q;
	assign rem_req.divisor  = cur_entry.period;

	ptd_ram #(
		.WIDTH(EW),
		.DEPTH(TASK_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(EW'(nxt_entry)),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ptd_rem u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (rem_req),
		.rsp   (rem_rsp)
	);

	// valid flag per slot, set on first write; flag read alongside the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (ram_we) begin
				vld_q[slot_q] <= 1'b1;
			end
			if (ram_re) begin
				rvld_s1 <= vld_q[ram_raddr];
			end
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tick_q      <= '0;
			idx_q       <= '0;
			op_q        <= OP_TICK;
			slot_q      <= '0;
			period_q    <= '0;
			ack_err_q   <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= 1'b0;
			status_q    <= 1'b0;
			due_slot_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= operation;
						slot_q    <= SW'(slot);
						period_q  <= period;
						ack_err_q <= (operation == OP_CREATE) && !has_function;
						if (operation == OP_TICK) begin
							tick_q  <= tick_q + 1'b1;
							idx_q   <= '0;
							state_q <= S_TK_RD;
						end else if (edits) begin
							state_q <= S_OP_WAIT;
						end else begin
							state_q <= S_ACK;
						end
					end
				end
				S_OP_WAIT: state_q <= S_ACK;
				S_ACK: begin
					if (out_free) begin
						kind_q      <= 1'b0;
						status_q    <= ack_err_q;
						due_slot_q  <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_TK_RD: state_q <= S_TK_WAIT;
				S_TK_WAIT: begin
					if (eligible) begin
						state_q <= S_TK_DIV;
					end else if (last_slot) begin
						state_q <= S_TK_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_TK_RD;
					end
				end
				S_TK_DIV: begin
					if (rem_rsp.done) begin
						if (rem_rsp.zero) begin
							state_q <= S_TK_EMIT;
						end else if (last_slot) begin
							state_q <= S_TK_DONE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_TK_RD;
						end
					end
				end
				S_TK_EMIT: begin
					if (out_free) begin
						kind_q      <= 1'b1;
						status_q    <= 1'b0;
						due_slot_q  <= SLOT_W'(idx_q);
						last_q      <= 1'b0;
						if (last_slot) begin
							state_q <= S_TK_DONE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_TK_RD;
						end
					end
				end
				S_TK_DONE: begin
					if (out_free) begin
						kind_q      <= 1'b0;
						status_q    <= 1'b0;
						due_slot_q  <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign status    = status_q;
	assign due_slot  = due_slot_q;
	assign last      = last_q;

	// remainder result only turns up while the sequencer waits for it
	a_rem_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.done |-> state_q == S_TK_DIV)
		else $error("remainder result outside period check");

	// slot walk stays inside the table
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(idx_q) < TASK_SLOTS)
		else $error("slot index beyond table");

	// a due item only ever belongs to a tick
	a_due_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind) |-> (op_q == OP_TICK && !last))
		else $error("due item outside tick transaction");

	// table write only follows a read issued at acceptance
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(accept))
		else $error("table write without preceding read");

endmodule
